// File: hw/rtl/eht_pkg.sv
`default_nettype none
package eht_pkg;

  // Default geometry
  localparam int MAX_GLOBAL_DEPTH_DEF = 8;
  localparam int NUM_BUCKETS_DEF      = 64;
  localparam int BUCKET_SLOTS_DEF     = 4;
  localparam int VALUE_BITS_DEF       = 32;

  // Field widths fixed by the interface
  localparam int KEY_W    = 64;
  localparam int PORT_V_W = 32;
  localparam int CFG_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 3'd4;

  // Operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [14:0] {
    S_INIT  = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_DIR   = 15'b000000000000100,
    S_META  = 15'b000000000001000,
    S_SCAN  = 15'b000000000010000,
    S_DBL   = 15'b000000000100000,
    S_SPLIT = 15'b000000001000000,
    S_RPT   = 15'b000000010000000,
    S_MOV   = 15'b000000100000000,
    S_FIN_B = 15'b000001000000000,
    S_FIN_N = 15'b000010000000000,
    S_RESP  = 15'b000100000000000,
    S_RSV0  = 15'b001000000000000,
    S_RSV1  = 15'b010000000000000,
    S_RSV2  = 15'b100000000000000
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/eht_ram.sv
`default_nettype none
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/extendible_hash_table.sv
// Extendible hash table with a directory, a bucket metadata store and a slot store,
// each a synchronous RAM with a registered read.
// Input channel (in_valid/in_stall): mode, key, value. mode 0 inserts, mode 1 looks up.
// Output channel (out_valid/out_stall): status and found_value, one result per item.
// Configuration: cfg_write with cfg_data sets the bucket capacity; write it only when idle.
// One item is worked at a time; in_stall is high while an item is in progress.
// Lookup: the directory entry, then the bucket metadata are read, then the bucket's slots
// are compared in order until a key matches or every filled slot has been compared.
// Insert into a bucket with room: the slot and the bucket's fill are written as the
// metadata is read; the next item is taken only after the result has been registered.
// A full bucket adds a split: the directory is doubled when the local depth has reached
// the global depth, a new bucket is taken, the directory entries of the old bucket with
// the split bit set are repointed to it, the filled slots are moved by that key bit,
// the metadata of both buckets is written back and the insert is retried.
// After reset the block seeds buckets 0 and 1 before it takes items.
// The result sits in an output register; a stalled receiver holds it, and the block
// may take the next item meanwhile but waits before presenting a new result.
// Status: 0 inserted, 1 lookup hit, 2 lookup miss, 3 insert dropped on overflow.
`default_nettype none
module extendible_hash_table #(
  parameter int MAX_GLOBAL_DEPTH = eht_pkg::MAX_GLOBAL_DEPTH_DEF,
  parameter int NUM_BUCKETS      = eht_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_SLOTS     = eht_pkg::BUCKET_SLOTS_DEF,
  parameter int VALUE_BITS       = eht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [eht_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            mode,
  input  wire logic [eht_pkg::KEY_W-1:0]       key,
  input  wire logic [eht_pkg::PORT_V_W-1:0]    value,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [eht_pkg::STATUS_W-1:0]    status,
  output logic      [eht_pkg::PORT_V_W-1:0]    found_value
);

  localparam int DW   = MAX_GLOBAL_DEPTH;
  localparam int BW   = $clog2(NUM_BUCKETS);
  localparam int UW   = $clog2(NUM_BUCKETS + 1);
  localparam int SLW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FW   = $clog2(BUCKET_SLOTS + 1);
  localparam int GW   = $clog2(MAX_GLOBAL_DEPTH + 1);
  localparam int SW   = (VALUE_BITS < eht_pkg::PORT_V_W) ? VALUE_BITS : eht_pkg::PORT_V_W;
  localparam int KW   = eht_pkg::KEY_W;
  localparam int MW   = FW + GW;
  localparam int SDW  = KW + SW;
  localparam int SAW  = BW + SLW;
  localparam int DBW  = (DW > 1) ? $clog2(DW) : 1;
  localparam int KBW  = $clog2(KW);

  eht_pkg::state_t state;

  logic                 init_idx;
  logic [GW-1:0]        gd;
  logic [UW-1:0]        used;
  logic [eht_pkg::CFG_W-1:0] cap_reg;
  logic                 mode_r;
  logic [KW-1:0]        key_r;
  logic [SW-1:0]        val_r;
  logic [BW-1:0]        b;
  logic [BW-1:0]        nb;
  logic [FW-1:0]        fill_b;
  logic [GW-1:0]        ld;
  logic [DW-1:0]        idx;
  logic [FW-1:0]        j;
  logic [FW-1:0]        keep;
  logic [FW-1:0]        nfill;
  logic [eht_pkg::STATUS_W-1:0] res_status;
  logic [SW-1:0]        res_value;

  // RAM ports
  logic           dir_we;
  logic [DW-1:0]  dir_waddr, dir_raddr;
  logic [BW-1:0]  dir_wdata, dir_rdata;
  logic           meta_we;
  logic [BW-1:0]  meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic           slot_we;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  logic [SDW-1:0] slot_wdata, slot_rdata;

  eht_ram #(.WIDTH(BW), .DEPTH(1 << DW)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  eht_ram #(.WIDTH(MW), .DEPTH(NUM_BUCKETS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  eht_ram #(.WIDTH(SDW), .DEPTH(NUM_BUCKETS << SLW)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  // Directory mask from the global depth; also the last index of the live half
  logic [DW-1:0] dmask;
  logic [DW-1:0] top;
  assign dmask = ~({DW{1'b1}} << gd);
  assign top   = dmask + DW'(1);

  // Effective bucket capacity
  logic [4:0]    cap5;
  logic [FW-1:0] cap;
  always_comb begin
    cap5 = {2'b00, cap_reg};
    if (cap5 == 5'd0) begin
      cap5 = 5'd1;
    end
    if (cap5 > 5'(BUCKET_SLOTS)) begin
      cap5 = 5'(BUCKET_SLOTS);
    end
    cap = FW'(cap5);
  end

  // Metadata fields as read
  logic [FW-1:0] m_fill;
  logic [GW-1:0] m_ld;
  assign m_fill = meta_rdata[MW-1:GW];
  assign m_ld   = meta_rdata[GW-1:0];

  logic need_dbl, no_split;
  assign need_dbl = (m_ld >= gd);
  assign no_split = (need_dbl && (gd >= GW'(MAX_GLOBAL_DEPTH))) ||
                    (used >= UW'(NUM_BUCKETS));

  // Slot data fields
  logic [KW-1:0] s_key;
  logic [SW-1:0] s_val;
  assign s_key = slot_rdata[SDW-1:SW];
  assign s_val = slot_rdata[SW-1:0];

  logic [FW-1:0] j_inc;
  assign j_inc = j + FW'(1);

  logic [GW-1:0] bit_sel;
  assign bit_sel = ld - GW'(1);

  // Split bit as an index into a directory index and into a key
  logic [DBW-1:0] dbit;
  logic [KBW-1:0] kbit;
  assign dbit = bit_sel[DBW-1:0];
  assign kbit = KBW'(bit_sel);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != eht_pkg::S_IDLE);

  // Drive RAM ports from the current step
  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = idx;
    dir_wdata  = nb;
    dir_raddr  = key_r[DW-1:0] & dmask;
    meta_we    = 1'b0;
    meta_waddr = b;
    meta_wdata = {keep, ld};
    meta_raddr = dir_rdata;
    slot_we    = 1'b0;
    slot_waddr = {b, m_fill[SLW-1:0]};
    slot_wdata = {key_r, val_r};
    slot_raddr = {b, {SLW{1'b0}}};
    unique case (state)
      eht_pkg::S_INIT: begin
        dir_we     = 1'b1;
        dir_waddr  = DW'(init_idx);
        dir_wdata  = BW'(init_idx);
        meta_we    = 1'b1;
        meta_waddr = BW'(init_idx);
        meta_wdata = {FW'(0), GW'(1)};
      end
      eht_pkg::S_IDLE: begin
        dir_raddr = key[DW-1:0] & dmask;
      end
      eht_pkg::S_META: begin
        if (mode_r == eht_pkg::MODE_INSERT && m_fill < cap) begin
          slot_we    = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = {m_fill + FW'(1), m_ld};
        end
        dir_raddr = '0;
      end
      eht_pkg::S_SCAN: begin
        slot_raddr = {b, j_inc[SLW-1:0]};
      end
      eht_pkg::S_DBL: begin
        dir_we    = 1'b1;
        dir_waddr = idx + top;
        dir_wdata = dir_rdata;
        dir_raddr = idx + DW'(1);
      end
      eht_pkg::S_SPLIT: begin
        dir_raddr = '0;
      end
      eht_pkg::S_RPT: begin
        dir_we    = (dir_rdata == b) && idx[dbit];
        dir_raddr = idx + DW'(1);
      end
      eht_pkg::S_MOV: begin
        slot_we    = 1'b1;
        slot_wdata = slot_rdata;
        if (s_key[kbit]) begin
          slot_waddr = {nb, nfill[SLW-1:0]};
        end else begin
          slot_waddr = {b, keep[SLW-1:0]};
        end
        slot_raddr = {b, j_inc[SLW-1:0]};
      end
      eht_pkg::S_FIN_B: begin
        meta_we = 1'b1;
      end
      eht_pkg::S_FIN_N: begin
        meta_we    = 1'b1;
        meta_waddr = nb;
        meta_wdata = {nfill, ld};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= eht_pkg::S_INIT;
      init_idx  <= 1'b0;
      gd        <= GW'(1);
      used      <= UW'(2);
      cap_reg   <= eht_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        cap_reg <= cfg_data;
      end
      // present a new result, or drop the one just transferred
      if (state == eht_pkg::S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        eht_pkg::S_INIT: begin
          init_idx <= 1'b1;
          if (init_idx) begin
            state <= eht_pkg::S_IDLE;
          end
        end
        eht_pkg::S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode;
            key_r  <= key;
            val_r  <= SW'(value);
            state  <= eht_pkg::S_DIR;
          end
        end
        eht_pkg::S_DIR: begin
          b     <= dir_rdata;
          state <= eht_pkg::S_META;
        end
        eht_pkg::S_META: begin
          fill_b <= m_fill;
          j      <= '0;
          if (mode_r == eht_pkg::MODE_LOOKUP) begin
            if (m_fill == FW'(0)) begin
              res_status <= eht_pkg::ST_MISS;
              res_value  <= '0;
              state      <= eht_pkg::S_RESP;
            end else begin
              state <= eht_pkg::S_SCAN;
            end
          end else if (m_fill < cap) begin
            res_status <= eht_pkg::ST_INSERTED;
            res_value  <= '0;
            state      <= eht_pkg::S_RESP;
          end else if (no_split) begin
            res_status <= eht_pkg::ST_OVERFLOW;
            res_value  <= '0;
            state      <= eht_pkg::S_RESP;
          end else begin
            ld  <= m_ld + GW'(1);
            idx <= '0;
            state <= need_dbl ? eht_pkg::S_DBL : eht_pkg::S_SPLIT;
          end
        end
        eht_pkg::S_SCAN: begin
          j <= j_inc;
          if (s_key == key_r) begin
            res_status <= eht_pkg::ST_HIT;
            res_value  <= s_val;
            state      <= eht_pkg::S_RESP;
          end else if (j_inc == fill_b) begin
            res_status <= eht_pkg::ST_MISS;
            res_value  <= '0;
            state      <= eht_pkg::S_RESP;
          end
        end
        eht_pkg::S_DBL: begin
          idx <= idx + DW'(1);
          if (idx == dmask) begin
            gd    <= gd + GW'(1);
            state <= eht_pkg::S_SPLIT;
          end
        end
        eht_pkg::S_SPLIT: begin
          nb    <= used[BW-1:0];
          used  <= used + UW'(1);
          idx   <= '0;
          state <= eht_pkg::S_RPT;
        end
        eht_pkg::S_RPT: begin
          idx <= idx + DW'(1);
          if (idx == dmask) begin
            j     <= '0;
            keep  <= '0;
            nfill <= '0;
            state <= eht_pkg::S_MOV;
          end
        end
        eht_pkg::S_MOV: begin
          j <= j_inc;
          if (s_key[kbit]) begin
            nfill <= nfill + FW'(1);
          end else begin
            keep <= keep + FW'(1);
          end
          if (j_inc == fill_b) begin
            state <= eht_pkg::S_FIN_B;
          end
        end
        eht_pkg::S_FIN_B: begin
          state <= eht_pkg::S_FIN_N;
        end
        eht_pkg::S_FIN_N: begin
          // retry the insert against the new layout
          state <= eht_pkg::S_DIR;
        end
        eht_pkg::S_RESP: begin
          if (out_free) begin
            status      <= res_status;
            found_value <= eht_pkg::PORT_V_W'(res_value);
            state       <= eht_pkg::S_IDLE;
          end
        end
        default: begin
          state <= eht_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
